// ===== src/cpso_pkg.sv =====
// Shared types, constants and helpers for the convex polygon overlap block.
package cpso_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int OVL_W        = 24;
    localparam logic [OVL_W-1:0] OVL_MAX = '1;
    localparam int DOT_W        = 34;
    localparam int R_W          = 34;
    localparam int LEN_W        = 34;
    localparam int T_W          = 76;
    localparam int P_W          = 58;
    localparam int CMP_W        = 84;
    localparam int BIT_W        = 5;
    localparam int SQ_CNT_W     = 6;

    typedef struct packed {
        logic               poly;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } vcmd_t;

    typedef struct packed {
        logic [OVL_W-1:0] amount;
        logic             sep;
        logic             bad;
    } result_t;

    // keep the low COORD_WIDTH bits, two's complement
    function automatic logic signed [15:0] coord_of(input logic [15:0] raw);
        logic signed [15:0] t;
        t = $signed(raw << (16 - COORD_WIDTH));
        return t >>> (16 - COORD_WIDTH);
    endfunction

endpackage

// ===== src/cpso_front.sv =====
// Input side: takes vertex words, formats them and queues them for the engine.
module cpso_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // vertex_x, vertex_y
    input  logic                   s_tuser,   // req_type
    input  logic                   s_tlast,   // last_vertex
    output logic                   q_valid,
    input  logic                   q_ready,
    output cpso_pkg::vcmd_t        q_cmd
);
    import cpso_pkg::*;

    vcmd_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    vcmd_t      cmd_in;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.poly = s_tuser;
        cmd_in.x    = coord_of(s_tdata[15:0]);
        cmd_in.y    = coord_of(s_tdata[31:16]);
        cmd_in.last = s_tlast;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// ===== src/cpso_back.sv =====
// Engine: vertex stores, edge sequencing, projections, serial square and root.
module cpso_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cpso_pkg::vcmd_t        q_cmd,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output cpso_pkg::result_t      m_res
);
    import cpso_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHECK  = 12'b000000000010,
        S_EDGE_A = 12'b000000000100,
        S_EDGE_B = 12'b000000001000,
        S_LEN    = 12'b000000010000,
        S_PROJ   = 12'b000000100000,
        S_DRAIN  = 12'b000001000000,
        S_CMP    = 12'b000010000000,
        S_SQR    = 12'b000100000000,
        S_ROOT   = 12'b001000000000,
        S_NEXT   = 12'b010000000000,
        S_RES    = 12'b100000000000
    } state_t;

    state_t st_reg, st_next;

    logic [31:0] store0 [MAX_VERTICES];
    logic [31:0] store1 [MAX_VERTICES];

    logic [CNT_W-1:0] cnt0_reg, cnt1_reg, cnt0_next, cnt1_next;
    logic             done0_reg, done1_reg, done0_next, done1_next;

    logic             k_reg, k_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] v_reg, v_next;
    logic             ph_reg, ph_next;
    logic signed [15:0] x0_reg, y0_reg, x0_next, y0_next;
    logic signed [16:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [32:0]      sqx_reg, sqy_reg, sqx_next, sqy_next;
    logic [LEN_W-1:0] len2_reg, len2_next;

    logic             pv_reg, pph_reg, pfirst_reg;
    logic signed [32:0] prodx_reg, prody_reg, prodx_next, prody_next;
    logic signed [DOT_W-1:0] alo_reg, ahi_reg, blo_reg, bhi_reg;
    logic signed [DOT_W-1:0] alo_next, ahi_next, blo_next, bhi_next;

    logic [T_W-1:0]   t_reg, t_next, m_reg, m_next;
    logic [R_W-1:0]   mpl_reg, mpl_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;

    logic [T_W-1:0]   rem_reg, rem_next;
    logic [P_W-1:0]   pacc_reg, pacc_next;
    logic [OVL_W-1:0] y_reg, y_next, best_reg, best_next;
    logic [BIT_W-1:0] bit_reg, bit_next;

    result_t          res_reg, res_next, out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    // combinational helpers
    logic             rd_poly;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      rd_vtx;
    logic signed [15:0] rd_x, rd_y;
    logic [CNT_W-1:0] na, nb, n_ph, j_idx;
    logic             wr_en;
    logic signed [DOT_W-1:0] dot, top, bot;
    logic signed [DOT_W:0]   span;
    logic [CMP_W-1:0] len_sh, delta;
    logic [OVL_W-1:0] y_try;
    logic             pop;

    assign na     = k_reg ? cnt1_reg : cnt0_reg;
    assign nb     = k_reg ? cnt0_reg : cnt1_reg;
    assign n_ph   = ph_reg ? nb : na;
    assign j_idx  = (i_reg + 1'b1 == na) ? '0 : i_reg + 1'b1;
    assign rd_vtx = rd_poly ? store1[rd_idx] : store0[rd_idx];
    assign rd_x   = $signed(rd_vtx[15:0]);
    assign rd_y   = $signed(rd_vtx[31:16]);
    assign dot    = DOT_W'(prodx_reg) + DOT_W'(prody_reg);
    assign top    = (ahi_reg < bhi_reg) ? ahi_reg : bhi_reg;
    assign bot    = (alo_reg > blo_reg) ? alo_reg : blo_reg;
    assign span   = (DOT_W+1)'(top) - (DOT_W+1)'(bot);
    assign len_sh = CMP_W'(len2_reg) << bit_reg;
    assign delta  = ((CMP_W'(pacc_reg) << 1) + len_sh) << bit_reg;

    assign q_ready  = (st_reg == S_IDLE);
    assign pop      = q_valid && q_ready;
    assign m_tvalid = out_valid_reg;
    assign m_res    = out_reg;

    always_comb
    begin
        rd_poly = k_reg;
        rd_idx  = i_reg[IDX_W-1:0];
        case (st_reg)
            S_EDGE_B: rd_idx = j_idx[IDX_W-1:0];
            S_PROJ:
            begin
                rd_poly = k_reg ^ ph_reg;
                rd_idx  = v_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb
    begin
        wr_en = 1'b0;
        if (pop)
        begin
            if (q_cmd.poly)
                wr_en = !done1_reg && (cnt1_reg < CNT_W'(MAX_VERTICES));
            else
                wr_en = !done0_reg && (cnt0_reg < CNT_W'(MAX_VERTICES));
        end
    end

    always_comb
    begin
        st_next        = st_reg;
        cnt0_next      = cnt0_reg;
        cnt1_next      = cnt1_reg;
        done0_next     = done0_reg;
        done1_next     = done1_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        v_next         = v_reg;
        ph_next        = ph_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        len2_next      = len2_reg;
        prodx_next     = prodx_reg;
        prody_next     = prody_reg;
        alo_next       = alo_reg;
        ahi_next       = ahi_reg;
        blo_next       = blo_reg;
        bhi_next       = bhi_reg;
        t_next         = t_reg;
        m_next         = m_reg;
        mpl_next       = mpl_reg;
        sq_cnt_next    = sq_cnt_reg;
        rem_next       = rem_reg;
        pacc_next      = pacc_reg;
        y_next         = y_reg;
        bit_next       = bit_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        y_try          = y_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        // projection second stage: fold one dot product into min/max
        if (pv_reg)
        begin
            if (!pph_reg)
            begin
                alo_next = (pfirst_reg || dot < alo_reg) ? dot : alo_reg;
                ahi_next = (pfirst_reg || dot > ahi_reg) ? dot : ahi_reg;
            end
            else
            begin
                blo_next = (pfirst_reg || dot < blo_reg) ? dot : blo_reg;
                bhi_next = (pfirst_reg || dot > bhi_reg) ? dot : bhi_reg;
            end
        end

        case (st_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (q_cmd.poly)
                    begin
                        if (!done1_reg)
                        begin
                            if (wr_en)
                                cnt1_next = cnt1_reg + 1'b1;
                            if (q_cmd.last)
                                done1_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!done0_reg)
                        begin
                            if (wr_en)
                                cnt0_next = cnt0_reg + 1'b1;
                            if (q_cmd.last)
                                done0_next = 1'b1;
                        end
                    end
                    if (done0_next && done1_next)
                        st_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cnt0_reg < CNT_W'(3) || cnt1_reg < CNT_W'(3))
                begin
                    res_next = '{amount: '0, sep: 1'b0, bad: 1'b1};
                    st_next  = S_RES;
                end
                else
                begin
                    k_next    = 1'b0;
                    i_next    = '0;
                    best_next = OVL_MAX;
                    st_next   = S_EDGE_A;
                end
            end
            S_EDGE_A:
            begin
                x0_next = rd_x;
                y0_next = rd_y;
                st_next = S_EDGE_B;
            end
            S_EDGE_B:
            begin
                dx_next = 17'(rd_x) - 17'(x0_reg);
                dy_next = 17'(rd_y) - 17'(y0_reg);
                if (rd_x == x0_reg && rd_y == y0_reg)
                    st_next = S_NEXT;
                else
                    st_next = S_LEN;
            end
            S_LEN:
            begin
                sqx_next = 33'($unsigned(34'(dx_reg) * 34'(dx_reg)));
                sqy_next = 33'($unsigned(34'(dy_reg) * 34'(dy_reg)));
                v_next   = '0;
                ph_next  = 1'b0;
                st_next  = S_PROJ;
            end
            S_PROJ:
            begin
                len2_next  = LEN_W'(sqx_reg) + LEN_W'(sqy_reg);
                prodx_next = 33'(rd_x) * (-33'(dy_reg));
                prody_next = 33'(rd_y) * 33'(dx_reg);
                if (v_reg + 1'b1 == n_ph)
                begin
                    v_next = '0;
                    if (!ph_reg)
                        ph_next = 1'b1;
                    else
                        st_next = S_DRAIN;
                end
                else
                    v_next = v_reg + 1'b1;
            end
            S_DRAIN:
                st_next = S_CMP;
            S_CMP:
            begin
                if (!(ahi_reg > blo_reg && alo_reg < bhi_reg))
                begin
                    res_next = '{amount: '0, sep: 1'b1, bad: 1'b0};
                    st_next  = S_RES;
                end
                else
                begin
                    // T = 256 * R^2 by shift and add
                    t_next      = '0;
                    m_next      = T_W'(span[R_W-1:0]) << 8;
                    mpl_next    = span[R_W-1:0];
                    sq_cnt_next = SQ_CNT_W'(R_W);
                    st_next     = S_SQR;
                end
            end
            S_SQR:
            begin
                if (sq_cnt_reg == '0)
                begin
                    rem_next  = t_reg;
                    pacc_next = '0;
                    y_next    = '0;
                    bit_next  = BIT_W'(OVL_W - 1);
                    st_next   = S_ROOT;
                end
                else
                begin
                    if (mpl_reg[0])
                        t_next = t_reg + m_reg;
                    m_next      = m_reg << 1;
                    mpl_next    = mpl_reg >> 1;
                    sq_cnt_next = sq_cnt_reg - 1'b1;
                end
            end
            S_ROOT:
            begin
                // largest y with y*y*len2 <= T; remainder tracks T - y*y*len2
                if (delta <= CMP_W'(rem_reg))
                begin
                    rem_next  = rem_reg - delta[T_W-1:0];
                    pacc_next = pacc_reg + len_sh[P_W-1:0];
                    y_try     = y_reg | (OVL_W'(1) << bit_reg);
                end
                y_next = y_try;
                if (bit_reg == '0)
                begin
                    if (y_try < best_reg)
                        best_next = y_try;
                    st_next = S_NEXT;
                end
                else
                    bit_next = bit_reg - 1'b1;
            end
            S_NEXT:
            begin
                if (i_reg + 1'b1 == na)
                begin
                    i_next = '0;
                    if (!k_reg)
                    begin
                        k_next  = 1'b1;
                        st_next = S_EDGE_A;
                    end
                    else
                    begin
                        res_next = '{amount: best_reg, sep: 1'b0, bad: 1'b0};
                        st_next  = S_RES;
                    end
                end
                else
                begin
                    i_next  = i_reg + 1'b1;
                    st_next = S_EDGE_A;
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    cnt0_next      = '0;
                    cnt1_next      = '0;
                    done0_next     = 1'b0;
                    done1_next     = 1'b0;
                    st_next        = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cnt0_reg      <= '0;
            cnt1_reg      <= '0;
            done0_reg     <= 1'b0;
            done1_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt0_reg      <= cnt0_next;
            cnt1_reg      <= cnt1_next;
            done0_reg     <= done0_next;
            done1_reg     <= done1_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= (st_reg == S_PROJ);
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        i_reg      <= i_next;
        v_reg      <= v_next;
        ph_reg     <= ph_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        len2_reg   <= len2_next;
        prodx_reg  <= prodx_next;
        prody_reg  <= prody_next;
        pph_reg    <= ph_reg;
        pfirst_reg <= (v_reg == '0);
        alo_reg    <= alo_next;
        ahi_reg    <= ahi_next;
        blo_reg    <= blo_next;
        bhi_reg    <= bhi_next;
        t_reg      <= t_next;
        m_reg      <= m_next;
        mpl_reg    <= mpl_next;
        sq_cnt_reg <= sq_cnt_next;
        rem_reg    <= rem_next;
        pacc_reg   <= pacc_next;
        y_reg      <= y_next;
        bit_reg    <= bit_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !q_cmd.poly)
            store0[cnt0_reg[IDX_W-1:0]] <= {q_cmd.y, q_cmd.x};
        if (wr_en && q_cmd.poly)
            store1[cnt1_reg[IDX_W-1:0]] <= {q_cmd.y, q_cmd.x};
    end

endmodule

// ===== src/convex_polygon_sat_overlap.sv =====
// Top level of the 2D convex polygon separating axis overlap block.
// Vertex words are taken one per cycle into a two-word queue while it has
// room, and stored by the engine one per cycle while it is idle. Once both
// polygons are closed the engine walks every edge of the first and then the
// second polygon: per edge two vertex reads, a squaring step, a projection
// step per vertex of both polygons, a drain and a compare step, a shift-add
// square of the overlap, a bit-serial root/divide and a step to the next
// edge, stopping early at the first separating axis. The result word leaves
// through an output register; vertices of the next pair queue up while the
// engine is busy.
module convex_polygon_sat_overlap (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vertex_x, vertex_y
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // overlap_amount
    output logic [1:0]  m_tuser    // separated, bad_polygon
);
    import cpso_pkg::*;

    logic    q_valid, q_ready;
    vcmd_t   q_cmd;
    result_t res;

    cpso_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    cpso_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    assign m_tdata = res.amount;
    assign m_tuser = {res.bad, res.sep};

endmodule

// ===== src/cpso_checker.sv =====
// Port-level checks for the polygon overlap block, bound to the top level.
module cpso_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("separated and bad polygon both set");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == 24'd0)
        else $error("nonzero overlap with separated or bad polygon");

    a_rst: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("result word right after reset");

endmodule

bind convex_polygon_sat_overlap cpso_checker u_cpso_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/convex_polygon_sat_overlap_tb.sv =====
// Self-checking testbench for the convex polygon separating axis overlap block.
module convex_polygon_sat_overlap_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpso_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    convex_polygon_sat_overlap i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    longint     poly_x [2][MAX_VERTICES];
    longint     poly_y [2][MAX_VERTICES];
    int         poly_cnt [2];
    bit         poly_closed [2];
    result_t    overlap_q [$];
    int         errors;
    int         idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint coord_val(input logic [15:0] raw);
        int         cw;
        logic [15:0] m;
        logic [15:0] v;
        cw = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
        m = 16'((17'd1 << cw) - 1);
        v = raw & m;
        if (v[cw-1])
            return longint'(v) - (longint'(1) << cw);
        return longint'(v);
    endfunction

    // floor(16*r/sqrt(len2)) by bit search, saturating to 24 bits
    function automatic logic [23:0] norm_overlap(input longint r, input longint len2);
        logic [127:0] t;
        logic [127:0] s;
        logic [23:0]  y;
        logic [63:0]  c;
        t = 128'(r * 16) * 128'(r * 16);
        y = '0;
        for (int b = 23; b >= 0; b--)
        begin
            c = 64'(y | (24'd1 << b));
            s = 128'(c * c) * 128'(len2);
            if (s <= t)
                y = c[23:0];
        end
        return y;
    endfunction

    function automatic void project_poly(input int p, input longint nx, input longint ny,
                                         output longint lo, output longint hi);
        longint d;
        lo = poly_x[p][0] * nx + poly_y[p][0] * ny;
        hi = lo;
        for (int i = 1; i < poly_cnt[p]; i++)
        begin
            d = poly_x[p][i] * nx + poly_y[p][i] * ny;
            if (d < lo) lo = d;
            if (d > hi) hi = d;
        end
    endfunction

    function automatic result_t sat_overlap();
        result_t    res;
        logic [23:0] best;
        logic [23:0] v;
        int         a, b, j;
        longint     dx, dy, alo, ahi, blo, bhi, top, bot;
        res = '0;
        best = OVL_MAX;
        for (int k = 0; k < 2; k++)
        begin
            a = k;
            b = 1 - k;
            for (int i = 0; i < poly_cnt[a]; i++)
            begin
                j = (i + 1 == poly_cnt[a]) ? 0 : i + 1;
                dx = poly_x[a][j] - poly_x[a][i];
                dy = poly_y[a][j] - poly_y[a][i];
                if (dx == 0 && dy == 0)
                    continue;
                project_poly(a, -dy, dx, alo, ahi);
                project_poly(b, -dy, dx, blo, bhi);
                if (!(ahi > blo && alo < bhi))
                begin
                    res.sep = 1'b1;
                    return res;
                end
                top = (ahi < bhi) ? ahi : bhi;
                bot = (alo > blo) ? alo : blo;
                v = norm_overlap(top - bot, dx * dx + dy * dy);
                if (v < best) best = v;
            end
        end
        res.amount = best;
        return res;
    endfunction

    function automatic void predict_vertex(input logic p, input logic [15:0] x,
                                           input logic [15:0] y, input logic last);
        result_t res;
        if (!poly_closed[p])
        begin
            if (poly_cnt[p] < MAX_VERTICES)
            begin
                poly_x[p][poly_cnt[p]] = coord_val(x);
                poly_y[p][poly_cnt[p]] = coord_val(y);
                poly_cnt[p]++;
            end
            if (last)
                poly_closed[p] = 1'b1;
        end
        if (!(poly_closed[0] && poly_closed[1]))
            return;
        res = '0;
        if (poly_cnt[0] < 3 || poly_cnt[1] < 3)
            res.bad = 1'b1;
        else
            res = sat_overlap();
        overlap_q.push_back(res);
        poly_cnt[0] = 0;
        poly_cnt[1] = 0;
        poly_closed[0] = 1'b0;
        poly_closed[1] = 1'b0;
    endfunction

    // valid stays up after a word is taken; it drops only when a gap follows
    task automatic send_vertex(input logic p, input logic [15:0] x, input logic [15:0] y,
                               input logic last);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= p;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_vertex(p, x, y, last);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (overlap_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    // polygon near (cx,cy): regular-ish convex shape with n vertices
    task automatic send_polygon(input logic p, input int n, input int cx, input int cy,
                                input int rad);
        real ang;
        int  x, y;
        for (int i = 0; i < n; i++)
        begin
            ang = 6.2831853 * i / n;
            x = cx + $rtoi(rad * $cos(ang));
            y = cy + $rtoi(rad * $sin(ang));
            send_vertex(p, 16'(x), 16'(y), i == n - 1);
        end
    endtask

    task automatic test_directed();
        // square vs square overlapping
        send_polygon(1'b0, 4, 0, 0, 160);
        send_polygon(1'b1, 4, 100, 0, 160);
        // touching square and triangle count as separated
        send_vertex(1'b0, 16'd0, 16'd0, 1'b0);
        send_vertex(1'b0, 16'd16, 16'd0, 1'b0);
        send_vertex(1'b0, 16'd16, 16'd16, 1'b0);
        send_vertex(1'b0, 16'd0, 16'd16, 1'b1);
        send_vertex(1'b1, 16'd16, 16'd0, 1'b0);
        send_vertex(1'b1, 16'd32, 16'd0, 1'b0);
        send_vertex(1'b1, 16'd16, 16'd16, 1'b1);
        // too few vertices, plus a vertex ignored after close
        send_vertex(1'b1, 16'h8000, 16'h7fff, 1'b1);
        send_vertex(1'b1, 16'h7fff, 16'h8000, 1'b1);
        send_polygon(1'b0, 3, 0, 0, 50);
        // degenerate polygons: all points equal -> no usable axis
        for (int i = 0; i < 3; i++) send_vertex(1'b0, 16'h8000, 16'h8000, i == 2);
        for (int i = 0; i < 3; i++) send_vertex(1'b1, 16'h8000, 16'h8000, i == 2);
    endtask

    task automatic test_overflow_vertices();
        // more than MAX_VERTICES, extreme coordinates
        for (int i = 0; i < MAX_VERTICES + 3; i++)
            send_vertex(1'b0, (i % 2) ? 16'h7fff : 16'h8000, (i % 3) ? 16'h8000 : 16'h7fff,
                        i == MAX_VERTICES + 2);
        send_polygon(1'b1, 5, 0, 0, 20000);
        drain_results();
    endtask

    task automatic test_random(input int n_items);
        int sent, n0, n1, r;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                // polygon pair, mostly small well-formed polygons
                n0 = $urandom_range(0, 7) == 0 ? $urandom_range(1, MAX_VERTICES + 2)
                                               : $urandom_range(3, 6);
                n1 = $urandom_range(0, 7) == 0 ? $urandom_range(1, MAX_VERTICES + 2)
                                               : $urandom_range(3, 6);
                if ($urandom_range(0, 1))
                begin
                    send_polygon(1'b0, n0, $urandom_range(0, 800) - 400,
                                 $urandom_range(0, 800) - 400, $urandom_range(1, 400));
                    send_polygon(1'b1, n1, $urandom_range(0, 800) - 400,
                                 $urandom_range(0, 800) - 400, $urandom_range(1, 400));
                end
                else
                begin
                    send_polygon(1'b1, n1, $urandom_range(0, 20000) - 10000,
                                 $urandom_range(0, 20000) - 10000, $urandom_range(1, 12000));
                    send_polygon(1'b0, n0, $urandom_range(0, 20000) - 10000,
                                 $urandom_range(0, 20000) - 10000, $urandom_range(1, 12000));
                end
                sent += n0 + n1;
            end
            else
            begin
                // raw noise vertex
                send_vertex(1'($urandom), 16'($urandom), 16'($urandom),
                            $urandom_range(0, 3) == 0);
                sent++;
            end
            if (sent > n_items / 2 && sent < n_items / 2 + 20)
                drain_results();
        end
        // close any open polygon so the last pair completes
        for (int p = 0; p < 2; p++)
            if (!poly_closed[p])
                for (int i = 0; i < 3; i++)
                    send_vertex(1'(p), 16'($urandom), 16'($urandom), i == 2);
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (overlap_q.size() == 0)
            begin
                $display("%0t: unexpected result amount=%0d user=%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                exp_r = overlap_q.pop_front();
                if (m_tdata !== exp_r.amount || m_tuser !== {exp_r.bad, exp_r.sep})
                begin
                    $display("%0t: expected amount=%0d sep=%b bad=%b, got amount=%0d sep=%b bad=%b",
                             $time, exp_r.amount, exp_r.sep, exp_r.bad, m_tdata, m_tuser[0],
                             m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
            m_tready   <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        poly_cnt    = '{0, 0};
        poly_closed = '{1'b0, 1'b0};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow_vertices();
        test_random(800);
        drain_results();
        if (errors == 0 && overlap_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
